>>> hdl/double_ended_queue_defines.svh
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define DEQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define DEQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/deq_pkg.sv
// Types, constants and pointer helpers for the double-ended queue.
package deq_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int KIND_W   = 2;
    localparam int WORD_W   = 64;
    localparam int BYTES_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_POP_BACK   = 2'd2,
        KIND_POP_FRONT  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [BYTES_W-1:0] bytes;
    } entry_t;

    function automatic ptr_t ptr_next(ptr_t p);
        return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

    function automatic ptr_t ptr_prev(ptr_t p);
        return (p == '0) ? ptr_t'(DEPTH - 1) : p - ptr_t'(1);
    endfunction

    // Count as seen on the result port: low COUNT_W bits of the held count.
    function automatic logic [COUNT_W-1:0] count_field(cnt_t c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[COUNT_W-1:0];
    endfunction

endpackage

>>> hdl/double_ended_queue.sv
// Double-ended queue of 64-bit words with byte lengths, held in a ring store.
`include "double_ended_queue_defines.svh"

// Each word is one operation (push back, push front, pop back, pop front) and gives
// exactly one result word: popped payload and length (zero unless a pop succeeded),
// status, and the entry count after the operation. A pop on an empty queue and a push
// on a full queue leave the queue untouched and report empty or full. Pushes and
// rejected operations load the result register when taken; a pop that succeeds reads
// memory into a read register first. The next word is taken once any earlier pop has
// returned its data and the result register is free or being drained in that cycle.
// The memory needs no clearing after reset: only written entries are ever read.
module double_ended_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [deq_pkg::KIND_W-1:0]    s_kind,
    input  logic [deq_pkg::WORD_W-1:0]    s_data_word,
    input  logic [deq_pkg::BYTES_W-1:0]   s_data_bytes,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [deq_pkg::WORD_W-1:0]    m_out_word,
    output logic [deq_pkg::BYTES_W-1:0]   m_out_bytes,
    output logic [deq_pkg::STATUS_W-1:0]  m_status,
    output logic [deq_pkg::COUNT_W-1:0]   m_entry_count
);
    import deq_pkg::*;

    entry_t entry_mem [DEPTH];
    entry_t rd_data_reg;

    ptr_t front_reg, front_next;
    ptr_t back_reg,  back_next;
    cnt_t count_reg, count_next;
    logic busy_reg,  busy_next;
    logic m_valid_reg, m_valid_next;

    logic [WORD_W-1:0]   out_word_reg,  out_word_next;
    logic [BYTES_W-1:0]  out_bytes_reg, out_bytes_next;
    status_t             status_reg,    status_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    kind_t   kind;
    logic    accept;
    logic    full;
    logic    empty;
    logic    wr_en;
    logic    rd_en;
    ptr_t    slot;
    status_t op_status;

    assign kind    = kind_t'(s_kind);
    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == cnt_t'(DEPTH));
    assign empty   = (count_reg == '0);

    // Operation decode: pointer moves and the single memory access
    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        slot       = front_reg;
        op_status  = STATUS_DONE;
        if (accept) begin
            case (kind)
                KIND_PUSH_BACK: begin
                    if (full) begin
                        op_status = STATUS_FULL;
                    end else begin
                        slot       = back_reg;
                        back_next  = ptr_next(back_reg);
                        count_next = count_reg + cnt_t'(1);
                        wr_en      = 1'b1;
                    end
                end
                KIND_PUSH_FRONT: begin
                    if (full) begin
                        op_status = STATUS_FULL;
                    end else begin
                        slot       = ptr_prev(front_reg);
                        front_next = ptr_prev(front_reg);
                        count_next = count_reg + cnt_t'(1);
                        wr_en      = 1'b1;
                    end
                end
                KIND_POP_BACK: begin
                    if (empty) begin
                        op_status = STATUS_EMPTY;
                    end else begin
                        slot       = ptr_prev(back_reg);
                        back_next  = ptr_prev(back_reg);
                        count_next = count_reg - cnt_t'(1);
                        rd_en      = 1'b1;
                    end
                end
                KIND_POP_FRONT: begin
                    if (empty) begin
                        op_status = STATUS_EMPTY;
                    end else begin
                        slot       = front_reg;
                        front_next = ptr_next(front_reg);
                        count_next = count_reg - cnt_t'(1);
                        rd_en      = 1'b1;
                    end
                end
                default: begin
                    op_status = STATUS_DONE;
                end
            endcase
        end
    end

    // Result register: loaded at accept, or in the cycle after accept for a pop
    always_comb begin
        busy_next      = rd_en;
        m_valid_next   = m_valid_reg && !m_ready;
        out_word_next  = out_word_reg;
        out_bytes_next = out_bytes_reg;
        status_next    = status_reg;
        out_count_next = out_count_reg;
        if (busy_reg) begin
            m_valid_next   = 1'b1;
            out_word_next  = rd_data_reg.word;
            out_bytes_next = rd_data_reg.bytes;
            status_next    = STATUS_DONE;
            out_count_next = count_field(count_reg);
        end else if (accept && !rd_en) begin
            m_valid_next   = 1'b1;
            out_word_next  = '0;
            out_bytes_next = '0;
            status_next    = op_status;
            out_count_next = count_field(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[slot] <= '{word: s_data_word, bytes: s_data_bytes};
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            back_reg    <= '0;
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            front_reg   <= front_next;
            back_reg    <= back_next;
            count_reg   <= count_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        out_bytes_reg <= out_bytes_next;
        status_reg    <= status_next;
        out_count_reg <= out_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_word    = out_word_reg;
    assign m_out_bytes   = out_bytes_reg;
    assign m_status      = status_reg;
    assign m_entry_count = out_count_reg;

    // Ring invariant: back sits count entries past front
    logic [PTR_W:0] ring_sum;
    logic [PTR_W:0] ring_wrap;
    logic           ring_ok;

    assign ring_sum  = {1'b0, front_reg} + (PTR_W + 1)'(count_reg);
    assign ring_wrap = (ring_sum >= (PTR_W + 1)'(DEPTH)) ? ring_sum - (PTR_W + 1)'(DEPTH)
                                                         : ring_sum;
    assign ring_ok   = (ring_wrap == {1'b0, back_reg});

    `DEQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= cnt_t'(DEPTH), "count above depth")
    `DEQ_ASSERT_IMP(a_ring_ok, 1'b1, ring_ok, "front, back and count disagree")
    `DEQ_ASSERT_NXT(a_pop_busy, rd_en, busy_reg && !s_ready, "pop read not held off")
    `DEQ_ASSERT_NXT(a_pop_result, busy_reg, m_valid_reg && status_reg == STATUS_DONE,
                    "pop data not delivered")

endmodule

>>> bench/tb.sv
// Self-checking testbench for the double-ended queue: directed and random operations.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;

    typedef struct {
        logic [WORD_W-1:0]  word;
        logic [BYTES_W-1:0] bytes;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } deq_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    kind_t                s_kind = KIND_PUSH_BACK;
    logic [WORD_W-1:0]    s_data_word = '0;
    logic [BYTES_W-1:0]   s_data_bytes = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [WORD_W-1:0]    m_out_word;
    logic [BYTES_W-1:0]   m_out_bytes;
    logic [STATUS_W-1:0]  m_status;
    logic [COUNT_W-1:0]   m_entry_count;

    // Shadow copy of the ring and its pointers
    logic [WORD_W-1:0]    shadow_word [DEPTH];
    logic [BYTES_W-1:0]   shadow_bytes [DEPTH];
    int                   head_idx = 0;
    int                   tail_idx = 0;
    int                   held = 0;

    deq_result_t          pending_results[$];
    int                   fail_count = 0;
    bit                   tx_idle_on = 1'b1;
    bit                   rx_stall_on = 1'b1;
    int                   rx_hold = 0;

    double_ended_queue DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_data_word   (s_data_word),
        .s_data_bytes  (s_data_bytes),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_word    (m_out_word),
        .m_out_bytes   (m_out_bytes),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Applies one operation to the shadow deque and queues the result it must give.
    function automatic void apply_deque_op(kind_t kind, logic [WORD_W-1:0] word,
                                           logic [BYTES_W-1:0] bytes);
        deq_result_t r;
        int          slot;
        r.word   = '0;
        r.bytes  = '0;
        r.status = STATUS_DONE;
        if (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) begin
            if (held >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                if (kind == KIND_PUSH_BACK) begin
                    slot     = tail_idx;
                    tail_idx = (tail_idx + 1) % DEPTH;
                end else begin
                    head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    slot     = head_idx;
                end
                shadow_word[slot]  = word;
                shadow_bytes[slot] = bytes;
                held++;
            end
        end else begin
            if (held == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                if (kind == KIND_POP_BACK) begin
                    tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                    slot     = tail_idx;
                end else begin
                    slot     = head_idx;
                    head_idx = (head_idx + 1) % DEPTH;
                end
                r.word  = shadow_word[slot];
                r.bytes = shadow_bytes[slot];
                held--;
            end
        end
        r.count = COUNT_W'(held);
        pending_results.push_back(r);
    endfunction

    // Offers one word and returns at the edge where it is taken.
    task automatic send_op(kind_t kind, logic [WORD_W-1:0] word, logic [BYTES_W-1:0] bytes);
        if (tx_idle_on) begin
            while ($urandom_range(0, 99) < 19) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_data_word  <= word;
        s_data_bytes <= bytes;
        do @(posedge aclk); while (!s_ready);
        apply_deque_op(kind, word, bytes);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [BYTES_W-1:0] pick_bytes();
        if ($urandom_range(0, 99) < 85) return BYTES_W'($urandom_range(0, 8));
        return BYTES_W'($urandom_range(9, 15));
    endfunction

    task automatic send_random_op(int push_pct);
        kind_t kind;
        if ($urandom_range(0, 99) < push_pct)
            kind = ($urandom_range(0, 1) != 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        else
            kind = ($urandom_range(0, 1) != 0) ? KIND_POP_FRONT : KIND_POP_BACK;
        send_op(kind, pick_word(), pick_bytes());
    endtask

    // Bursts that lean toward pushes or pops so the count sweeps between empty and full.
    task automatic run_random_bursts(int n_ops);
        int done_ops;
        int burst;
        int push_pct;
        done_ops = 0;
        while (done_ops < n_ops) begin
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 20;
                default: push_pct = 50;
            endcase
            burst = $urandom_range(4, 40);
            repeat (burst) send_random_op(push_pct);
            done_ops += burst;
        end
    endtask

    task automatic test_empty_pops();
        send_op(KIND_POP_BACK, '1, 4'hf);
        send_op(KIND_POP_FRONT, 64'h0123_4567_89ab_cdef, 4'd8);
    endtask

    task automatic test_field_extremes();
        send_op(KIND_PUSH_BACK, '1, 4'hf);
        send_op(KIND_PUSH_FRONT, '0, 4'd0);
        send_op(KIND_PUSH_BACK, 64'h8000_0000_0000_0001, 4'd8);
        send_op(KIND_PUSH_FRONT, 64'h5a5a_a5a5_0f0f_f0f0, 4'd9);
        send_op(KIND_POP_FRONT, '0, '0);
        send_op(KIND_POP_BACK, '1, '1);
        send_op(KIND_POP_FRONT, '0, '0);
        send_op(KIND_POP_BACK, '0, '0);
    endtask

    // Fill to capacity from both ends, then try to push past it.
    task automatic test_full_queue();
        for (int i = 0; i < DEPTH; i++)
            send_op((i % 2) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_word(), pick_bytes());
        send_op(KIND_PUSH_BACK, '1, 4'hf);
        send_op(KIND_PUSH_FRONT, '1, 4'hf);
    endtask

    task automatic test_random_traffic();
        run_random_bursts(650);
    endtask

    task automatic test_back_to_back();
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        run_random_bursts(200);
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // Receiver stalls as words keep coming; sender awaits full drain, then more bursts.
    task automatic test_output_backpressure();
        rx_hold = HOLD_CYCLES;
        tx_idle_on = 1'b0;
        repeat (30) send_random_op(60);
        tx_idle_on = 1'b1;
        s_valid <= 1'b0;
        wait_drained();
        run_random_bursts(120);
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_stall_on) begin
            m_ready <= ($urandom_range(0, 99) >= 19);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        deq_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_out_word !== want.word) begin
                    $error("out_word: expected %h, got %h", want.word, m_out_word);
                    fail_count++;
                end
                if (m_out_bytes !== want.bytes) begin
                    $error("out_bytes: expected %0d, got %0d", want.bytes, m_out_bytes);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, m_entry_count);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_pops();
        test_field_extremes();
        test_full_queue();
        test_random_traffic();
        test_back_to_back();
        test_output_backpressure();
        s_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
